[rtl/bounded_exact_match_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the exact-match table block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_EXACT_MATCH_TABLE_ASSERT_SVH
`define BOUNDED_EXACT_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication.
`define BEMT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define BEMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/bemt_pkg.sv]
// ----------------------------------------------------------------------------
// bemt_pkg
// Shared types, codes and helpers for the exact-match table block.
// ----------------------------------------------------------------------------
package bemt_pkg;

    localparam int NUM_TABLES_DEF = 4;
    localparam int ENTRIES_DEF    = 256;
    localparam int KEY_BITS_DEF   = 64;

    localparam int FIELD_BITS = 64;
    localparam int COUNT_BITS = 9;
    localparam int CFG_BITS   = 9;

    typedef enum logic [2:0] {
        OP_UPDATE = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_DELETE = 3'd2,
        OP_SIZE   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NOTFOUND = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTABLE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAX_ENTRIES   = 2'd0,
        CFG_KEY_BYTES     = 2'd1,
        CFG_VALUE_BYTES   = 2'd2,
        CFG_TABLE_PRESENT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CLEAR,
        ST_EXEC
    } state_t;

    // What a new request needs: a table search, a clearing sweep, or nothing.
    typedef enum logic [1:0] {
        K_SCAN,
        K_CLEAR,
        K_NOW
    } kind_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic clr;
        logic init;
        logic exec;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  last_slot;
        logic  last_all;
    } stat_t;

    // Mask keeping the low nbytes bytes of a 64-bit word.
    function automatic logic [FIELD_BITS-1:0] byte_mask(input logic [3:0] nbytes);
        logic [5:0] sh;
        sh = {nbytes[2:0], 3'b000};
        if (nbytes >= 4'd8)
            byte_mask = '1;
        else
            byte_mask = (64'd1 << sh) - 64'd1;
    endfunction

endpackage

[rtl/bemt_ram.sv]
// ----------------------------------------------------------------------------
// bemt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bemt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bemt_ctrl.sv]
// ----------------------------------------------------------------------------
// bemt_ctrl
// Sequencer for reset sweep, table scan, clearing sweep and execution.
// ----------------------------------------------------------------------------
module bemt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  bemt_pkg::stat_t stat,
    output bemt_pkg::cmd_t  cmd,
    output logic            busy
);
    import bemt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:  if (stat.last_all) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start)
                begin
                    case (stat.kind)
                        K_SCAN:  state_next = ST_SCAN;
                        K_CLEAR: state_next = ST_CLEAR;
                        default: state_next = ST_EXEC;
                    endcase
                end
            end
            ST_SCAN:  if (stat.last_slot) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_EXEC;
            ST_CLEAR: if (stat.last_slot) state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_IDLE;
            default:  state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_INIT:  cmd.init = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:  cmd.scan = 1'b1;
            ST_CLEAR: cmd.clr  = 1'b1;
            ST_EXEC:  cmd.exec = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

[rtl/bemt_dp.sv]
// ----------------------------------------------------------------------------
// bemt_dp
// Datapath: configuration, request latch, slot RAM, match search, counts.
// ----------------------------------------------------------------------------
module bemt_dp #(
    parameter int NUM_TABLES = bemt_pkg::NUM_TABLES_DEF,
    parameter int ENTRIES    = bemt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = bemt_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bemt_pkg::cmd_t                      cmd,
    output bemt_pkg::stat_t                     stat,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [bemt_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic [2:0]                          req_type,
    input  logic [1:0]                          table_sel,
    input  logic [bemt_pkg::FIELD_BITS-1:0]     key,
    input  logic [bemt_pkg::FIELD_BITS-1:0]     new_value,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [bemt_pkg::FIELD_BITS-1:0]     read_value,
    output logic [bemt_pkg::COUNT_BITS-1:0]     entry_count
);
    import bemt_pkg::*;

    localparam int TOTAL = NUM_TABLES * ENTRIES;
    localparam int AW    = $clog2(TOTAL);
    localparam int TSW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int WW    = 1 + KEY_BITS + FIELD_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);
    localparam logic [AW-1:0] LAST_ALL  = AW'(TOTAL - 1);

    // Configuration registers.
    logic [COUNT_BITS-1:0] max_entries_reg;
    logic [3:0]            key_bytes_reg;
    logic [3:0]            value_bytes_reg;
    logic [3:0]            present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= COUNT_BITS'(256);
            key_bytes_reg   <= 4'd8;
            value_bytes_reg <= 4'd8;
            present_reg     <= 4'hF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES:   max_entries_reg <= cfg_data;
                CFG_KEY_BYTES:     key_bytes_reg   <= cfg_data[3:0];
                CFG_VALUE_BYTES:   value_bytes_reg <= cfg_data[3:0];
                CFG_TABLE_PRESENT: present_reg     <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // Decode of the incoming request.
    logic in_absent;
    logic [FIELD_BITS-1:0] key_m;
    logic [FIELD_BITS-1:0] val_m;

    assign in_absent = (3'(table_sel) >= 3'(NUM_TABLES)) || !present_reg[table_sel];
    assign key_m     = key & byte_mask(key_bytes_reg);
    assign val_m     = new_value & byte_mask(value_bytes_reg);

    // Latched request.
    logic [2:0]            op_reg;
    logic [TSW-1:0]        tsel_reg;
    logic                  absent_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [FIELD_BITS-1:0] val_reg;
    logic [AW-1:0]         base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req_type;
            tsel_reg   <= table_sel[TSW-1:0];
            absent_reg <= in_absent;
            key_reg    <= key_m[KEY_BITS-1:0];
            val_reg    <= val_m;
            base_reg   <= AW'(AW'(table_sel) * AW'(ENTRIES));
        end
    end

    // Sweep counter.
    logic [AW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= '0;
        else if (cmd.scan || cmd.clr || cmd.init)
            cnt_reg <= cnt_reg + AW'(1);
    end

    // Status toward the controller: sweep position and the kind of request.
    always_comb
    begin
        stat.last_slot = (cnt_reg == LAST_SLOT);
        stat.last_all  = (cnt_reg == LAST_ALL);
        if (in_absent)
            stat.kind = K_NOW;
        else if (req_type inside {OP_UPDATE, OP_LOOKUP, OP_DELETE})
            stat.kind = K_SCAN;
        else if (req_type == OP_CLEAR)
            stat.kind = K_CLEAR;
        else
            stat.kind = K_NOW;
    end

    // Slot RAM: {valid, key, value}.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [WW-1:0] ram_rdata;

    assign ram_raddr = base_reg + cnt_reg;

    bemt_ram #(
        .WIDTH(WW),
        .DEPTH(TOTAL)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.scan),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Match search on the data that each registered read returns in the next cycle.
    logic                  cmp_vld_reg;
    logic [AW-1:0]         cmp_addr_reg;
    logic                  found_reg;
    logic                  free_reg;
    logic [AW-1:0]         hit_addr_reg;
    logic [AW-1:0]         free_addr_reg;
    logic [FIELD_BITS-1:0] hit_val_reg;
    logic                  rd_valid;
    logic                  rd_match;

    assign rd_valid = ram_rdata[WW-1];
    assign rd_match = rd_valid && (ram_rdata[FIELD_BITS +: KEY_BITS] == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (rd_match && !found_reg)
                    found_reg <= 1'b1;
                if (!rd_valid && !free_reg)
                    free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= ram_raddr;
        if (cmp_vld_reg && rd_match && !found_reg)
        begin
            hit_addr_reg <= cmp_addr_reg;
            hit_val_reg  <= ram_rdata[FIELD_BITS-1:0];
        end
        if (cmp_vld_reg && !rd_valid && !free_reg)
            free_addr_reg <= cmp_addr_reg;
    end

    // Live counts and execution.
    logic [COUNT_BITS-1:0] live_count_reg [NUM_TABLES];
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] new_count;
    status_t               res_status;
    logic [FIELD_BITS-1:0] res_value;

    assign cur_count = absent_reg ? '0 : live_count_reg[tsel_reg];

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg;
        ram_wdata  = {1'b0, key_reg, val_reg};
        res_status = STS_OK;
        res_value  = '0;
        new_count  = cur_count;
        if (cmd.init)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.clr)
        begin
            ram_we    = 1'b1;
            ram_waddr = base_reg + cnt_reg;
        end
        else if (cmd.exec)
        begin
            if (absent_reg)
            begin
                res_status = STS_NOTABLE;
            end
            else
            begin
                case (op_reg)
                    OP_UPDATE:
                    begin
                        if (found_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_addr_reg;
                            ram_wdata = {1'b1, key_reg, val_reg};
                        end
                        else if (cur_count >= max_entries_reg || !free_reg)
                        begin
                            res_status = STS_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = free_addr_reg;
                            ram_wdata = {1'b1, key_reg, val_reg};
                            new_count = cur_count + COUNT_BITS'(1);
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (found_reg)
                            res_value = hit_val_reg;
                        else
                            res_status = STS_NOTFOUND;
                    end
                    OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_addr_reg;
                            if (cur_count != '0)
                                new_count = cur_count - COUNT_BITS'(1);
                        end
                        else
                        begin
                            res_status = STS_NOTFOUND;
                        end
                    end
                    OP_CLEAR: new_count = '0;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TABLES; i++)
                live_count_reg[i] <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.exec;
            if (cmd.exec && !absent_reg)
                live_count_reg[tsel_reg] <= new_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status      <= res_status;
            read_value  <= res_value;
            entry_count <= new_count;
        end
    end

endmodule

[rtl/bounded_exact_match_table.sv]
// ----------------------------------------------------------------------------
// bounded_exact_match_table
// Up to four exact-match key/value tables behind a start/busy command port.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// for exactly one cycle with done high, and the receiver cannot stall it.
// After reset the block sweeps all NUM_TABLES*ENTRIES slots to clear their
// valid marks, with busy high throughout. Update, lookup and delete scan
// every slot of the addressed table through the single read port of the
// slot RAM, then drain the last read before they execute. Clear writes
// each slot of the table once before it executes. Size queries, unknown
// operations and requests to an absent table go straight to execution.
// One request is handled at a time.
// Configuration may be written at any time the block is idle.
module bounded_exact_match_table #(
    parameter int NUM_TABLES = bemt_pkg::NUM_TABLES_DEF,
    parameter int ENTRIES    = bemt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = bemt_pkg::KEY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [bemt_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      req_type,
    input  logic [1:0]                      table_sel,
    input  logic [bemt_pkg::FIELD_BITS-1:0] key,
    input  logic [bemt_pkg::FIELD_BITS-1:0] new_value,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [bemt_pkg::FIELD_BITS-1:0] read_value,
    output logic [bemt_pkg::COUNT_BITS-1:0] entry_count
);
    import bemt_pkg::*;

    `include "bounded_exact_match_table_assert.svh"

    cmd_t  cmd;
    stat_t stat;

    // The controller only sequences; all storage lives in the datapath.
    bemt_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy)
    );

    bemt_dp #(
        .NUM_TABLES(NUM_TABLES),
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .table_sel  (table_sel),
        .key        (key),
        .new_value  (new_value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .entry_count(entry_count)
    );

    // An accepted request keeps the block busy until its result is out.
    `BEMT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    // A result is only produced by a request that was in flight.
    `BEMT_ASSERT_IMPL(a_done_from_busy, done, $past(busy))
    // Absent tables report neither a value nor a count.
    `BEMT_ASSERT_IMPL(a_notable_zero, done && status == STS_NOTABLE,
                      read_value == '0 && entry_count == '0)
    // A nonzero value only comes back with a successful request.
    `BEMT_ASSERT_IMPL(a_value_ok, done && read_value != '0, status == STS_OK)

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for bounded_exact_match_table
// Drives table requests through the start/busy port, predicts every result in
// a scoreboard that keeps its own copy of the tables, and compares each
// result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import bemt_pkg::*;

    localparam int TABLES = 4;
    localparam int SLOTS  = 256;

    // One predicted response of the block.
    typedef struct {
        status_t      status;
        logic [63:0]  value;
        logic [8:0]   count;
    } table_reply_t;

    // Scoreboard: a model of the four tables plus the queue of predicted replies.
    class table_scoreboard;
        logic [8:0]   capacity;
        logic [3:0]   key_len;
        logic [3:0]   val_len;
        logic [3:0]   present;
        bit           used [TABLES*SLOTS];
        logic [63:0]  stored_key [TABLES*SLOTS];
        logic [63:0]  stored_val [TABLES*SLOTS];
        int unsigned  live [TABLES];
        table_reply_t replies [$];
        int           errors;

        function void reset_state();
            capacity = 9'd256;
            key_len  = 4'd8;
            val_len  = 4'd8;
            present  = 4'hF;
            foreach (used[i]) used[i] = 1'b0;
            foreach (live[i]) live[i] = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [8:0] data);
            case (idx)
                CFG_MAX_ENTRIES:   capacity = data;
                CFG_KEY_BYTES:     key_len  = data[3:0];
                CFG_VALUE_BYTES:   val_len  = data[3:0];
                CFG_TABLE_PRESENT: present  = data[3:0];
                default: ;
            endcase
        endfunction

        // Keep the low n bytes of a 64-bit word; n of 8 or more keeps all.
        function logic [63:0] low_bytes(logic [3:0] n);
            if (n >= 4'd8)
                return {64{1'b1}};
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        function int find_slot(int base, logic [63:0] k);
            for (int s = 0; s < SLOTS; s++)
                if (used[base+s] && stored_key[base+s] == k)
                    return s;
            return -1;
        endfunction

        function int free_slot(int base);
            for (int s = 0; s < SLOTS; s++)
                if (!used[base+s])
                    return s;
            return -1;
        endfunction

        // Apply one accepted request to the model and queue its reply.
        function void note_request(logic [2:0] op, logic [1:0] tsel,
                                   logic [63:0] k_in, logic [63:0] v_in);
            table_reply_t r;
            logic [63:0]  k;
            logic [63:0]  v;
            int           base;
            int           hit;
            k = k_in & low_bytes(key_len);
            v = v_in & low_bytes(val_len);
            r.status = STS_OK;
            r.value  = '0;
            r.count  = '0;
            if (!present[tsel]) begin
                r.status = STS_NOTABLE;
                replies.push_back(r);
                return;
            end
            base = tsel * SLOTS;
            case (op)
                OP_UPDATE: begin
                    hit = find_slot(base, k);
                    if (hit >= 0)
                        stored_val[base+hit] = v;
                    else if (live[tsel] >= capacity)
                        r.status = STS_FULL;
                    else begin
                        hit = free_slot(base);
                        if (hit < 0)
                            r.status = STS_FULL;
                        else begin
                            used[base+hit]       = 1'b1;
                            stored_key[base+hit] = k;
                            stored_val[base+hit] = v;
                            live[tsel]++;
                        end
                    end
                end
                OP_LOOKUP: begin
                    hit = find_slot(base, k);
                    if (hit >= 0)
                        r.value = stored_val[base+hit];
                    else
                        r.status = STS_NOTFOUND;
                end
                OP_DELETE: begin
                    hit = find_slot(base, k);
                    if (hit >= 0) begin
                        used[base+hit] = 1'b0;
                        if (live[tsel] > 0)
                            live[tsel]--;
                    end
                    else
                        r.status = STS_NOTFOUND;
                end
                OP_CLEAR: begin
                    for (int s = 0; s < SLOTS; s++)
                        used[base+s] = 1'b0;
                    live[tsel] = 0;
                end
                default: ;
            endcase
            r.count = live[tsel][8:0];
            replies.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [63:0] val, logic [8:0] cnt);
            table_reply_t e;
            if (replies.size() == 0) begin
                $display("%0t: unexpected result status=%0d value=%h count=%0d",
                         $time, st, val, cnt);
                errors++;
                return;
            end
            e = replies.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (val !== e.value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.value, val);
                errors++;
            end
            if (cnt !== e.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [1:0]  table_sel;
    logic [63:0] key;
    logic [63:0] new_value;
    logic        done;
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [8:0]  entry_count;

    table_scoreboard sb;

    // Pool of keys reused within a phase, so that requests hit stored entries.
    logic [63:0] key_pool [32];
    int          gap_pct;

    bounded_exact_match_table i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .table_sel   (table_sel),
        .key         (key),
        .new_value   (new_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Results stay up for a single cycle and cannot be held off, so every
    // rising edge with done high carries exactly one result.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, read_value, entry_count);
    end

    // Hard stop in case the block hangs: the slowest correct run, including
    // the clearing sweep after reset, stays well below this.
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Send one request. Before raising start the sender may idle for a few
    // cycles; the request is taken at the first edge where busy is low.
    task automatic send(logic [2:0] op, logic [1:0] tsel, logic [63:0] k, logic [63:0] v);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= op;
        table_sel <= tsel;
        key       <= k;
        new_value <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(op, tsel, k, v);
    endtask

    // Let every pending result arrive, then give the block a short margin
    // so that it is surely idle before registers change.
    task automatic drain();
        start <= 1'b0;
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [8:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [8:0] cap, logic [3:0] kb, logic [3:0] vb,
                             logic [3:0] tp);
        write_reg(CFG_MAX_ENTRIES, cap);
        write_reg(CFG_KEY_BYTES, {5'd0, kb});
        write_reg(CFG_VALUE_BYTES, {5'd0, vb});
        write_reg(CFG_TABLE_PRESENT, {5'd0, tp});
    endtask

    // A phase of random requests. Most keys come from the pool, so updates,
    // lookups and deletes find what earlier requests stored.
    task automatic random_phase(int count);
        logic [2:0]  op;
        logic [63:0] k;
        int          pick;
        foreach (key_pool[i]) key_pool[i] = rand64();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 36)
                op = OP_UPDATE;
            else if (pick < 66)
                op = OP_LOOKUP;
            else if (pick < 82)
                op = OP_DELETE;
            else if (pick < 90)
                op = OP_SIZE;
            else if (pick < 93)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(7, 5));
            if ($urandom_range(99) < 80)
                k = key_pool[$urandom_range(31)];
            else
                k = rand64();
            send(op, 2'($urandom_range(3)), k, rand64());
        end
    endtask

    // Fill one table with fresh keys until it runs out of slots, with a
    // lookup now and then, so the full case is reached at the top capacity.
    task automatic fill_phase(logic [1:0] tsel, int count);
        for (int n = 0; n < count; n++) begin
            if (n % 10 == 9)
                send(OP_LOOKUP, tsel, key_pool[$urandom_range(31)], rand64());
            else
                send(OP_UPDATE, tsel, rand64(), rand64());
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        req_type  = '0;
        table_sel = '0;
        key       = '0;
        new_value = '0;
        gap_pct   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait out the clearing sweep that follows reset.
        do
            @(posedge clk);
        while (busy);

        // Directed requests at the reset settings: extreme keys and values,
        // overwrite of a present key, missing keys, size, clear and the
        // unknown operation codes.
        send(OP_UPDATE, 2'd0, {64{1'b1}}, {64{1'b1}});
        send(OP_LOOKUP, 2'd0, {64{1'b1}}, '0);
        send(OP_UPDATE, 2'd0, {64{1'b1}}, 64'h0123_4567_89AB_CDEF);
        send(OP_LOOKUP, 2'd0, {64{1'b1}}, {64{1'b1}});
        send(OP_UPDATE, 2'd3, '0, '0);
        send(OP_LOOKUP, 2'd3, '0, {64{1'b1}});
        send(OP_LOOKUP, 2'd3, 64'h1, '0);
        send(OP_DELETE, 2'd3, 64'h8000_0000_0000_0000, '0);
        send(OP_SIZE, 2'd0, '0, '0);
        send(OP_DELETE, 2'd0, {64{1'b1}}, '0);
        send(OP_DELETE, 2'd0, {64{1'b1}}, '0);
        send(OP_UPDATE, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send(3'd5, 2'd1, '0, '0);
        send(3'd6, 2'd2, {64{1'b1}}, {64{1'b1}});
        send(3'd7, 2'd1, '0, '0);
        send(OP_CLEAR, 2'd1, '0, '0);
        send(OP_LOOKUP, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send(OP_SIZE, 2'd3, '0, '0);
        drain();

        // Phases of random traffic. Each line picks a setting and a sender
        // idling rate; the settings cover the range ends of the byte-count
        // and table-present registers, absent tables, byte counts over eight,
        // a capacity of zero, and one lowered beneath the count already held.
        configure(9'd256, 4'd8, 4'd8, 4'hF); gap_pct = 0;  random_phase(200); drain();
        configure(9'd3,   4'd2, 4'd1, 4'hA); gap_pct = 72; random_phase(200); drain();
        configure(9'd0,   4'd1, 4'd8, 4'hF); gap_pct = 14; random_phase(100); drain();
        configure(9'd256, 4'd8, 4'd8, 4'h4); gap_pct = 0;  fill_phase(2'd2, 300); drain();
        configure(9'd5,   4'd3, 4'd0, 4'hF); gap_pct = 72; random_phase(150); drain();
        configure(9'd200, 4'd15, 4'd4, 4'h0); gap_pct = 14; random_phase(50); drain();
        configure(9'd17,  4'd4, 4'd15, 4'h7); gap_pct = 0; random_phase(250); drain();
        configure(9'd256, 4'd0, 4'd9, 4'hD); gap_pct = 72; random_phase(100); drain();

        // drain() already waited for every result plus a margin.
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
